@@ rtl/core/nlrc_pkg.sv @@
// Package for the nonlinear recurrence bit codec: widths, register indexes,
// reset values and the micro-op codes of the shared multiplier sequencer.
// No dependencies.
package nlrc_pkg;

  localparam int unsigned BlockLen  = 64;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned PosW      = $clog2(BlockLen);
  localparam int unsigned WordW     = 60;
  localparam int unsigned FullW     = 64;
  localparam int unsigned HalfW     = 32;
  localparam int unsigned RateW     = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 60;

  localparam logic [CfgIdxW-1:0] RegDirection = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInitState = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInitWa    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInitWb    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLearnRate = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCubicGain = 3'd5;

  localparam logic [WordW-1:0] RstInitState = 60'd6553;
  localparam logic [WordW-1:0] RstInitWa    = 60'd39321;
  localparam logic [WordW-1:0] RstInitWb    = 60'd26214;
  localparam logic [RateW-1:0] RstLearnRate = 32'd327;
  localparam logic [RateW-1:0] RstCubicGain = 32'd32768;

  localparam logic [FullW-1:0] OneQ = 64'd1 << FracBits;

  // sequencer steps; each but idle and done issues one product on the shared multiplier
  typedef enum logic [3:0] {
    StIdle,
    StDelta1,   // t = (s*x)>>F          (decode: state*tx; encode: nrx*rx)
    StDelta2,   // delta = (eta*t)>>F, weight update
    StXwa,      // lin = (x*wa)>>F
    StXwb,      // xw = (x*wb)>>F
    StSq,       // sq = (xw*xw)>>F
    StCube,     // cu = sq*xw
    StGain,     // ct = ((c*cu)>>F)>>F, form result
    StDone
  } seq_state_e;

  // multiplier steps: three 32x32 partial products, then the result
  typedef enum logic [1:0] {
    MulLoLo,
    MulLoHi,
    MulHiLo,
    MulDone
  } mul_step_e;

  typedef struct packed {
    logic [FullW-1:0] op_a;
    logic [FullW-1:0] op_b;
  } mul_req_t;

endpackage

@@ rtl/core/nlrc_mul.sv @@
// Shared multiplier: 64x64 product mod 2^64 built from three 32x32 partial
// products on one 32x32 multiplier, one per step, then a done step. Depends on nlrc_pkg.
module nlrc_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  nlrc_pkg::mul_req_t         req_i,
  output logic [nlrc_pkg::FullW-1:0] prod_o,
  output logic                       done_o
);
  import nlrc_pkg::*;

  mul_step_e        step_q, step_d;
  logic [FullW-1:0] acc_q, acc_d;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [FullW-1:0] mul_p;

  // operands must hold steady while start_i is high
  always_comb begin
    step_d = step_q;
    unique case (step_q)
      MulLoLo: if (start_i) step_d = MulLoHi;
      MulLoHi: step_d = MulHiLo;
      MulHiLo: step_d = MulDone;
      MulDone: step_d = MulLoLo;
      default: step_d = MulLoLo;
    endcase
  end

  always_comb begin
    mul_a = req_i.op_a[HalfW-1:0];
    mul_b = req_i.op_b[HalfW-1:0];
    unique case (step_q)
      MulLoHi: mul_b = req_i.op_b[FullW-1:HalfW];
      MulHiLo: mul_a = req_i.op_a[FullW-1:HalfW];
      default: ;
    endcase
  end

  assign mul_p = FullW'(mul_a) * FullW'(mul_b);

  // cross terms only reach the upper half mod 2^64
  always_comb begin
    acc_d = acc_q;
    unique case (step_q) inside
      MulLoLo:          acc_d = mul_p;
      MulLoHi, MulHiLo: acc_d[FullW-1:HalfW] = acc_q[FullW-1:HalfW] + mul_p[HalfW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= MulLoLo;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;
  assign done_o = (step_q == MulDone);
endmodule

@@ rtl/core/nonlinear_recurrence_bit_codec.sv @@
// Nonlinear recurrence bit codec, top level: handshake, config registers,
// recurrence state and the multiplier sequencer. Depends on nlrc_pkg, nlrc_mul.
//
// Usage: configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while
// idle. Input words arrive on s_axis (tdata fields, low bit up: data_bit,
// sample_word, block_key, block_weight_a, block_weight_b). Each accepted word
// yields exactly one output word on m_axis (stream_word, decoded_bit,
// end_state, end_weight_a, end_weight_b in tdata; block_end on tlast).
// Sequence: an item runs through seven dependent products on one shared unit
// that builds each 64-bit product from three 32x32 partials and then presents
// it registered. Encode closes with a Done step after the seven products;
// decode finishes in its last product step, Gain.
// s_axis_tready is low while an item is at work and while the previous result
// still sits in the output register, so no new word is taken before the last
// one is through and its result has left; a stalled receiver holds the result
// and back-pressures the input.
// Reset: the configuration registers take their documented reset values, state and
// weights equal the initial registers, block position is zero.
// Writing the direction register restarts the block.
module nonlinear_recurrence_bit_codec (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [59:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // data_bit[0], sample_word[64:1], block_key[128:65], block_weight_a[188:129],
  // block_weight_b[248:189], zero pad to 256
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // stream_word[59:0], decoded_bit[60], end_state[120:61], end_weight_a[180:121],
  // end_weight_b[240:181], zero pad to 248
  output logic [247:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import nlrc_pkg::*;

  // configuration
  logic             dir_q;
  logic [WordW-1:0] init_s_q, init_wa_q, init_wb_q;
  logic [RateW-1:0] eta_q, gain_q;

  // recurrence state
  logic [FullW-1:0] state_q, state_d;
  logic [WordW-1:0] wa_q, wa_d, wb_q, wb_d;
  logic [PosW-1:0]  pos_q, pos_d;

  // per-item working registers
  logic [FullW-1:0] x_q, x_d;       // multiplicand (rx or tx)
  logic [FullW-1:0] tmp_q, tmp_d;   // t, lin or nrx, by step
  logic [FullW-1:0] xw_q, xw_d;
  logic [FullW-1:0] sq_q, sq_d;
  logic             bit_q, bit_d;
  seq_state_e       st_q, st_d;

  // output register
  logic             ov_q, ov_d;
  logic [247:0]     od_q, od_d;
  logic             ol_q, ol_d;

  mul_req_t         req;
  logic [FullW-1:0] prod, prod_sh, delta;
  logic             mul_start, mul_done;
  logic             in_acc, last, cfg_dir_wr;

  // input fields
  logic             in_bit;
  logic [FullW-1:0] in_word, in_key;
  logic [WordW-1:0] in_wa, in_wb;

  assign in_bit  = s_axis_tdata[0];
  assign in_word = s_axis_tdata[64:1];
  assign in_key  = s_axis_tdata[128:65];
  assign in_wa   = s_axis_tdata[188:129];
  assign in_wb   = s_axis_tdata[248:189];

  assign s_axis_tready = (st_q == StIdle) && !ov_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign last          = (pos_q == PosW'(BlockLen - 1));
  assign cfg_dir_wr    = cfg_we_i && (cfg_idx_i == RegDirection);
  assign prod_sh       = prod >> FracBits;
  // every step but idle and done runs one product
  assign mul_start     = (st_q != StIdle) && (st_q != StDone);

  nlrc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .req_i   (req),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q     <= 1'b0;
      init_s_q  <= RstInitState;
      init_wa_q <= RstInitWa;
      init_wb_q <= RstInitWb;
      eta_q     <= RstLearnRate;
      gain_q    <= RstCubicGain;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDirection: dir_q     <= cfg_data_i[0];
        RegInitState: init_s_q  <= cfg_data_i;
        RegInitWa:    init_wa_q <= cfg_data_i;
        RegInitWb:    init_wb_q <= cfg_data_i;
        RegLearnRate: eta_q     <= cfg_data_i[RateW-1:0];
        RegCubicGain: gain_q    <= cfg_data_i[RateW-1:0];
        default: ;
      endcase
    end
  end

  // next state of the sequencer; decode finishes in StGain
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:   if (in_acc) st_d = dir_q ? StDelta1 : StXwa;
      StDelta1: if (mul_done) st_d = StDelta2;
      StDelta2: if (mul_done) st_d = dir_q ? StXwa : StDone;
      StXwa:    if (mul_done) st_d = StXwb;
      StXwb:    if (mul_done) st_d = StSq;
      StSq:     if (mul_done) st_d = StCube;
      StCube:   if (mul_done) st_d = StGain;
      StGain:   if (mul_done) st_d = dir_q ? StIdle : StDelta1;
      StDone:   st_d = StIdle;
      default:  st_d = StIdle;
    endcase
  end

  // multiplier operands
  always_comb begin
    req.op_a = x_q;
    req.op_b = x_q;
    unique case (st_q)
      StDelta1: begin req.op_a = dir_q ? state_q : tmp_q; req.op_b = x_q; end
      StDelta2: begin req.op_a = FullW'(eta_q); req.op_b = tmp_q; end
      StXwa:    begin req.op_a = x_q; req.op_b = FullW'(wa_q); end
      StXwb:    begin req.op_a = x_q; req.op_b = FullW'(wb_q); end
      StSq:     begin req.op_a = xw_q; req.op_b = xw_q; end
      StCube:   begin req.op_a = sq_q; req.op_b = xw_q; end
      StGain:   begin req.op_a = FullW'(gain_q); req.op_b = sq_q; end
      default: ;
    endcase
  end

  // datapath and output
  always_comb begin
    logic [FullW-1:0] ct, base, nrx, p0, p1, pb0, pb1, hb, d0, d1;
    state_d = state_q;
    wa_d    = wa_q;
    wb_d    = wb_q;
    pos_d   = pos_q;
    x_d     = x_q;
    tmp_d   = tmp_q;
    xw_d    = xw_q;
    sq_d    = sq_q;
    bit_d   = bit_q;
    ov_d    = ov_q;
    od_d    = od_q;
    ol_d    = ol_q;
    delta   = prod_sh;
    ct      = prod_sh >> FracBits;
    base    = tmp_q + ct;
    nrx     = (base + (bit_q ? OneQ : '0)) & ((64'd1 << WordW) - 64'd1);
    p0      = base & ((64'd1 << WordW) - 64'd1);
    p1      = (base + OneQ) & ((64'd1 << WordW) - 64'd1);
    pb0     = p0 + (64'd1 << 63);
    pb1     = p1 + (64'd1 << 63);
    hb      = state_q ^ (64'd1 << 63);
    d0      = (pb0 >= hb) ? pb0 - hb : hb - pb0;
    d1      = (pb1 >= hb) ? pb1 - hb : hb - pb1;

    if (m_axis_tvalid && m_axis_tready) ov_d = 1'b0;

    case (st_q)
      StIdle: if (in_acc) begin
        bit_d = in_bit;
        if (dir_q) begin
          x_d = in_word;
          if (pos_q == '0) begin
            state_d = in_key;
            wa_d    = in_wa;
            wb_d    = in_wb;
          end
        end else begin
          if (pos_q == '0) begin
            state_d = FullW'(init_s_q);
            wa_d    = init_wa_q;
            wb_d    = init_wb_q;
            x_d     = FullW'(init_s_q);
          end else begin
            x_d = state_q;
          end
        end
      end
      StDelta1: if (mul_done) tmp_d = prod_sh;
      StDelta2: if (mul_done) begin
        if (dir_q) begin
          wa_d = wa_q - delta[WordW-1:0];
          wb_d = wb_q + delta[WordW-1:0];
        end else begin
          wa_d = wa_q + delta[WordW-1:0];
          wb_d = wb_q - delta[WordW-1:0];
        end
      end
      StXwa:  if (mul_done) tmp_d = prod_sh;
      StXwb:  if (mul_done) xw_d = prod_sh;
      StSq:   if (mul_done) sq_d = prod_sh;
      StCube: if (mul_done) sq_d = prod;
      StGain: if (mul_done) begin
        if (dir_q) begin
          od_d       = '0;
          od_d[60]   = !(d0 < d1);
          ol_d       = last;
          state_d    = x_q;
        end else begin
          // encode: nrx ready, delta still to compute against rx
          tmp_d   = nrx;
          state_d = nrx;
        end
      end
      StDone: begin
        ov_d = 1'b1;
        if (!dir_q) begin
          od_d          = '0;
          od_d[59:0]    = x_q[WordW-1:0];
          ol_d          = last;
          if (last) begin
            od_d[120:61]  = state_q[WordW-1:0];
            od_d[180:121] = wa_q;
            od_d[240:181] = wb_q;
          end
        end
        pos_d = last ? '0 : pos_q + PosW'(1);
      end
      default: ;
    endcase
    // decode finishes in StGain: flag output and advance there
    if (st_q == StGain && mul_done && dir_q) begin
      ov_d  = 1'b1;
      pos_d = last ? '0 : pos_q + PosW'(1);
    end
    if (cfg_dir_wr) pos_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      ov_q    <= 1'b0;
      pos_q   <= '0;
      state_q <= FullW'(RstInitState);
      wa_q    <= RstInitWa;
      wb_q    <= RstInitWb;
    end else begin
      st_q    <= st_d;
      ov_q    <= ov_d;
      pos_q   <= pos_d;
      state_q <= state_d;
      wa_q    <= wa_d;
      wb_q    <= wb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    tmp_q <= tmp_d;
    xw_q  <= xw_d;
    sq_q  <= sq_d;
    bit_q <= bit_d;
    od_q  <= od_d;
    ol_q  <= ol_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;

  // no new item while a result is pending or an item runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q || st_q != StIdle) |-> !s_axis_tready)
    else $error("input taken while busy");

  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // an accepted item leaves idle next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q != StIdle))
    else $error("sequencer did not start");
endmodule
